>>> rtl/core/dcmf_pkg.sv
// Shared types, codes and constants of the dark channel minimum filter.
`default_nettype none
package dcmf_pkg;

    // Defaults of the top-level size parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_PATCH  = 25;

    // Register reset values
    localparam int PATCH_RST  = 15;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // Work queue between front and back
    localparam int QUEUE_DEPTH = 16;

    // Input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PATCH  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    // Header of one queued emission group: count, first column, row, frame end
    typedef struct packed {
        logic [5:0] cnt;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } t_qhdr;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/dcmf_ifs.sv
// Handshake interfaces of the pixel, result and configuration channels.
`default_nettype none
interface dcmf_pix_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    modport source (output valid, command, blue, green, red, input ready);
    modport sink   (input valid, command, blue, green, red, output ready);
endinterface

interface dcmf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] dark_value;
    logic [9:0] out_row;
    logic [9:0] out_col;
    logic       last_of_frame;
    modport source (output valid, dark_value, out_row, out_col, last_of_frame, input ready);
    modport sink   (input valid, dark_value, out_row, out_col, last_of_frame, output ready);
endinterface

interface dcmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dcmf_ram.sv
// Generic simple dual-port RAM with registered read, read-before-write.
`default_nettype none
module dcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read, old data on a collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/dcmf_queue.sv
// Small FIFO of emission groups between the front and the back.
`default_nettype none
module dcmf_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic      [CW-1:0]    o_count
);
    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (int'(r_wp) == DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (int'(r_rp) == DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_data  = r_buf[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_count = r_cnt;
endmodule
`default_nettype wire

>>> rtl/core/dcmf_front.sv
// Front: accepts pixels, keeps line buffers, forms column and prefix minima.
`default_nettype none
module dcmf_front #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PATCH  = dcmf_pkg::DEF_MAX_PATCH,
    localparam int PEAK_PATCH = (MAX_PATCH - 1) | 1,
    localparam int MAX_RAD    = (PEAK_PATCH - 1) / 2,
    localparam int QCW        = $clog2(dcmf_pkg::QUEUE_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    dcmf_pix_if.sink                i_pix,
    dcmf_cfg_if.sink                i_cfg,
    input  wire logic [QCW-1:0]     i_q_count,
    output logic                    o_push,
    output dcmf_pkg::t_qhdr         o_hdr,
    output logic [MAX_RAD:0][7:0]   o_vals
);
    import dcmf_pkg::*;

    localparam int LINE_ROWS = PEAK_PATCH - 1;
    localparam int SW  = $clog2(LINE_ROWS);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + MAX_RAD);
    localparam int RDW = $clog2(MAX_RAD + 1);
    localparam int KW  = $clog2(PEAK_PATCH);
    localparam int NG  = (LINE_ROWS + 7) / 8;

    typedef struct packed {
        logic           emit;
        t_qhdr          hdr;
        logic [RDW-1:0] jstart;
        logic [RDW-1:0] rad;
        logic [CW-1:0]  col;
    } t_meta;

    function automatic logic [RDW-1:0] f_rad(input logic [4:0] p);
        logic [5:0] q;
        q = {1'b0, p} | 6'd1;
        if (q < 6'd3) q = 6'd3;
        if (int'(q) > PEAK_PATCH) q = 6'(PEAK_PATCH);
        return RDW'((q - 6'd1) >> 1);
    endfunction

    function automatic logic [WW-1:0] f_wid(input logic [10:0] w);
        if (w == '0) return WW'(1);
        if (int'(w) > MAX_WIDTH) return WW'(MAX_WIDTH);
        return WW'(w);
    endfunction

    function automatic logic [HW-1:0] f_hgt(input logic [10:0] h);
        if (h == '0) return HW'(1);
        if (int'(h) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
        return HW'(h);
    endfunction

    // Configuration registers
    logic [4:0]  r_patch;
    logic [10:0] r_width, r_height;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_patch  <= 5'(PATCH_RST);
            r_width  <= 11'(WIDTH_RST);
            r_height <= 11'(HEIGHT_RST);
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_PATCH:  r_patch  <= i_cfg.data[4:0];
                REG_WIDTH:  r_width  <= i_cfg.data;
                REG_HEIGHT: r_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Position state and latched geometry
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_col;
    logic [SW-1:0]  r_slot;
    logic [RDW-1:0] r_rad;
    logic [WW-1:0]  r_wid;
    logic [HW-1:0]  r_hgt;

    logic           acc, latch, take, burst, row_ok, col_ok;
    logic [RDW-1:0] e_rad, jstart;
    logic [WW-1:0]  e_wid;
    logic [HW-1:0]  e_hgt;
    logic [CW-1:0]  col_c;
    logic [RW-1:0]  orow;
    logic [7:0]     cur;
    logic [LINE_ROWS-1:0] mask;
    t_meta          meta0;
    int             dk;

    // Classify the beat and pick the geometry it runs with
    always_comb begin
        acc   = i_pix.valid && i_pix.ready;
        latch = acc && (r_row == '0) && (r_col == '0) && (i_pix.command == CMD_PIXEL);
        e_rad = latch ? f_rad(r_patch)  : r_rad;
        e_wid = latch ? f_wid(r_width)  : r_wid;
        e_hgt = latch ? f_hgt(r_height) : r_hgt;
        take  = acc && (i_pix.command ==
                        ((r_row >= RW'(e_hgt)) ? CMD_FLUSH : CMD_PIXEL));
        col_c = (WW'(r_col) >= e_wid) ? CW'(e_wid - WW'(1)) : r_col;
        cur   = (i_pix.command == CMD_FLUSH) ? 8'hFF
              : min8(min8(i_pix.blue, i_pix.green), i_pix.red);
    end

    // Work out which results this beat completes
    always_comb begin
        burst  = (WW'(col_c) == e_wid - WW'(1));
        row_ok = (r_row >= RW'(e_rad));
        col_ok = (WW'(col_c) >= WW'(e_rad));
        jstart = (burst && !col_ok) ? RDW'(col_c) : e_rad;
        orow   = r_row - RW'(e_rad);
        meta0.emit     = row_ok && (burst || col_ok);
        meta0.hdr.cnt  = burst ? 6'(jstart) + 6'd1 : 6'd1;
        meta0.hdr.col  = 10'(col_c - CW'(jstart));
        meta0.hdr.row  = 10'(orow);
        meta0.hdr.last = burst && (orow == RW'(e_hgt) - RW'(1));
        meta0.jstart   = jstart;
        meta0.rad      = e_rad;
        meta0.col      = col_c;
    end

    // Select the line slots that hold rows inside the window
    always_comb begin
        dk = 0;
        for (int k = 0; k < LINE_ROWS; k++) begin
            dk = int'(r_slot) - k;
            if (dk <= 0) dk = dk + LINE_ROWS;
            mask[k] = (dk <= 2 * int'(e_rad)) && (dk <= int'(r_row))
                   && (dk + int'(e_hgt) > int'(r_row));
        end
    end

    // Advance position and latch geometry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
            r_rad  <= f_rad(5'(PATCH_RST));
            r_wid  <= f_wid(11'(WIDTH_RST));
            r_hgt  <= f_hgt(11'(HEIGHT_RST));
        end else begin
            if (latch) begin
                r_rad <= e_rad;
                r_wid <= e_wid;
                r_hgt <= e_hgt;
            end
            if (take) begin
                if (burst) begin
                    r_col <= '0;
                    if (int'(r_row) + 1 >= int'(e_hgt) + int'(e_rad)) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_slot <= (int'(r_slot) == LINE_ROWS - 1) ? '0 : r_slot + SW'(1);
                    end
                end else begin
                    r_col <= col_c + CW'(1);
                end
            end
        end
    end

    // Line buffers, one per stored row slot
    logic [7:0] rdata [LINE_ROWS];

    for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
        dcmf_ram #(
            .WIDTH (8),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (take && (i_pix.command == CMD_PIXEL) && (int'(r_slot) == k)),
            .i_waddr (col_c),
            .i_wdata (cur),
            .i_raddr (col_c),
            .o_rdata (rdata[k])
        );
    end

    // Stage 1: read data arrives, reduce in groups of eight
    logic                 r_s1_v;
    logic [LINE_ROWS-1:0] r_s1_mask;
    logic [7:0]           r_s1_cur;
    t_meta                r_s1_meta;
    logic [7:0]           grp [NG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= take;
        end
        r_s1_mask <= mask;
        r_s1_cur  <= cur;
        r_s1_meta <= meta0;
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp[g] = 8'hFF;
            for (int j = 0; j < 8; j++) begin
                if ((g * 8 + j < LINE_ROWS) && r_s1_mask[(g * 8 + j) % LINE_ROWS]) begin
                    grp[g] = min8(grp[g], rdata[(g * 8 + j) % LINE_ROWS]);
                end
            end
        end
    end

    // Stage 2: column minimum over the groups and the new pixel
    logic       r_s2_v;
    logic [7:0] r_s2_grp [NG];
    logic [7:0] r_s2_cur;
    t_meta      r_s2_meta;
    logic [7:0] colmin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_grp  <= grp;
        r_s2_cur  <= r_s1_cur;
        r_s2_meta <= r_s1_meta;
    end

    always_comb begin
        colmin = r_s2_cur;
        for (int g = 0; g < NG; g++) begin
            colmin = min8(colmin, r_s2_grp[g]);
        end
    end

    // Stage 3: shift prefix minima of recent columns, pick result values
    logic       r_s3_v;
    logic [7:0] r_s3_m;
    t_meta      r_s3_meta;
    logic [7:0] r_pm   [PEAK_PATCH];
    logic [7:0] pm_new [PEAK_PATCH];
    int         t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
            for (int k = 0; k < PEAK_PATCH; k++) begin
                r_pm[k] <= 8'hFF;
            end
        end else begin
            r_s3_v <= r_s2_v;
            if (r_s3_v) begin
                r_pm <= pm_new;
            end
        end
        r_s3_m    <= colmin;
        r_s3_meta <= r_s2_meta;
    end

    always_comb begin
        pm_new[0] = r_s3_m;
        for (int k = 1; k < PEAK_PATCH; k++) begin
            pm_new[k] = min8(r_s3_m, r_pm[k - 1]);
        end
    end

    always_comb begin
        t = 0;
        for (int i = 0; i <= MAX_RAD; i++) begin
            t = int'(r_s3_meta.jstart) + int'(r_s3_meta.rad) - i;
            if (t < 0) t = 0;
            if (t > int'(r_s3_meta.col)) t = int'(r_s3_meta.col);
            o_vals[i] = pm_new[KW'(t)];
        end
    end

    assign o_push = r_s3_v && r_s3_meta.emit;
    assign o_hdr  = r_s3_meta.hdr;

    // Hold off input while the queue may not absorb the beats in flight
    assign i_pix.ready = (int'(i_q_count) + int'(r_s1_v) + int'(r_s2_v) + int'(r_s3_v))
                         < QUEUE_DEPTH;
endmodule
`default_nettype wire

>>> rtl/core/dcmf_back.sv
// Back: unrolls queued groups into single results behind an output register.
`default_nettype none
module dcmf_back #(
    parameter int MAX_RAD = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  dcmf_pkg::t_qhdr            i_hdr,
    input  wire logic [MAX_RAD:0][7:0] i_vals,
    output logic                       o_pop,
    dcmf_res_if.source                 o_res
);
    import dcmf_pkg::*;

    localparam int IW = $clog2(MAX_RAD + 1);

    logic       r_ovalid;
    logic [5:0] r_idx;
    logic       fire, fin;

    assign fire  = i_valid && (!r_ovalid || o_res.ready);
    assign fin   = (r_idx == i_hdr.cnt - 6'd1);
    assign o_pop = fire && fin;

    // Step through the group, drop it after its last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (fire) begin
                r_ovalid <= 1'b1;
                r_idx    <= fin ? 6'd0 : r_idx + 6'd1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Load the output beat
    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_res.dark_value    <= i_vals[IW'(r_idx)];
            o_res.out_row       <= i_hdr.row;
            o_res.out_col       <= i_hdr.col + 10'(r_idx);
            o_res.last_of_frame <= i_hdr.last && fin;
        end
    end

    assign o_res.valid = r_ovalid;
endmodule
`default_nettype wire

>>> rtl/core/dark_channel_min_filter_core.sv
// Top level of the streaming dark channel minimum filter.
//
//  channel  | dir | payload                                      | role
//  i_pix    | in  | command, blue, green, red                    | pixels and flush beats
//  o_res    | out | dark_value, out_row, out_col, last_of_frame  | patch minima
//  i_cfg    | in  | index, data                                  | register writes
//
//  One input beat per cycle when ready; beats pass the front stage registers to the queue.
//  A row end yields up to R+1 results, sent one per cycle from the back end unless stalled.
//  Input stalls when queue entries plus beats in flight reach the queue depth.
//  Reset is synchronous; line buffers need no clearing, rows are written before use.
`default_nettype none
module dark_channel_min_filter_core #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PATCH  = dcmf_pkg::DEF_MAX_PATCH
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    dcmf_pix_if.sink   i_pix,
    dcmf_cfg_if.sink   i_cfg,
    dcmf_res_if.source o_res
);
    import dcmf_pkg::*;

    localparam int PEAK_PATCH = (MAX_PATCH - 1) | 1;
    localparam int MAX_RAD    = (PEAK_PATCH - 1) / 2;
    localparam int QCW        = $clog2(QUEUE_DEPTH + 1);
    localparam int QW         = $bits(t_qhdr) + (MAX_RAD + 1) * 8;

    logic                  push, pop, q_valid;
    t_qhdr                 f_hdr, q_hdr;
    logic [MAX_RAD:0][7:0] f_vals, q_vals;
    logic [QW-1:0]         q_data;
    logic [QCW-1:0]        q_count;

    dcmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PATCH  (MAX_PATCH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (i_cfg),
        .i_q_count (q_count),
        .o_push    (push),
        .o_hdr     (f_hdr),
        .o_vals    (f_vals)
    );

    dcmf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_hdr, f_vals}),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_count (q_count)
    );

    assign {q_hdr, q_vals} = q_data;

    dcmf_back #(
        .MAX_RAD (MAX_RAD)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_hdr   (q_hdr),
        .i_vals  (q_vals),
        .o_pop   (pop),
        .o_res   (o_res)
    );

    // Queue never overflows: input throttling covers every beat in flight
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |-> (int'(q_count) < QUEUE_DEPTH))
        else $error("group queue overflow");

    // Back end pops only a present group
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q_count != '0))
        else $error("pop from empty group queue");

    // Taking a beat implies room for it downstream
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> (int'(q_count) <= QUEUE_DEPTH))
        else $error("queue count out of range");
endmodule
`default_nettype wire
